### rtl/s3dfd_pkg.sv
// Shared types, constants and the colour classifier of the stereo 3D frame detector.
package s3dfd_pkg;

   localparam int PALETTE_ENTRIES = 32;
   localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
   localparam int COLOR_W         = 6;
   localparam int SKIP_W          = 5;
   localparam int TURBO_PERIOD    = 18;
   localparam int BG_END          = 12;
   localparam int SPR_START       = 24;

   // Request payload layout, lowest bit first.
   localparam int REQ_IDX_LSB   = 0;
   localparam int REQ_VAL_LSB   = REQ_IDX_LSB + PAL_AW;
   localparam int REQ_SHUT_BIT  = REQ_VAL_LSB + COLOR_W;
   localparam int REQ_TURBO_BIT = REQ_SHUT_BIT + 1;
   localparam int REQ_SKIP_LSB  = REQ_TURBO_BIT + 1;
   localparam int REQ_USED_W    = REQ_SKIP_LSB + SKIP_W;
   localparam int REQ_W         = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_W         = 8;

   typedef enum logic [1:0] {
      TINT_NONE  = 2'd0,
      TINT_RED   = 2'd1,
      TINT_CYAN  = 2'd2,
      TINT_OTHER = 2'd3
   } tint_type;

   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_SHUTTER  = 2'd1,
      MODE_ANAGLYPH = 2'd2
   } mode_type;

   typedef enum logic {
      OP_PAL_WRITE = 1'b0,
      OP_FRAME     = 1'b1
   } op_type;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan_read;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic in_frame;
      logic need_scan;
      logic scan_last;
      logic rsp_free;
   } status_type;

   function automatic tint_type colour_class(input logic [COLOR_W-1:0] c);
      tint_type k;
      unique case (c)
         6'h00, 6'h0F:                      k = TINT_NONE;
         6'h05, 6'h15, 6'h06, 6'h16:        k = TINT_RED;
         6'h01, 6'h11, 6'h0A, 6'h1A,
         6'h0C, 6'h1C, 6'h2C:               k = TINT_CYAN;
         default:                           k = TINT_OTHER;
      endcase
      return k;
   endfunction

endpackage

### rtl/stereo_3d_frame_detector_core.sv
// Top level of the stereo 3D frame detector: sequencer and datapath.
//
// Channel   Direction  Transfer moves
// req_*     in         one palette write (tuser 0) or one frame start (tuser 1)
// rsp_*     out        one detection result per frame start, none per palette write
//
// A palette write is stored as it is taken. A frame start moves through the
// transfer, setup and commit when the glasses pin decides the frame; when the
// palette test runs, the setup is followed by a walk of the 20 checked entries
// through the single read port of the palette memory, one entry per cycle, and
// by a step for the read latency before the commit.
// Reset clears the history and the palette valid bits at once, so unwritten entries
// read as black; there is no clearing pass. A result waits in its output register
// while the next item is taken; a frame finishing while that register is full
// holds until rsp_tready frees it.
module stereo_3d_frame_detector_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // req_tuser: op (0 palette write, 1 frame start)
   input  logic                          req_tuser,
   // req_tdata from bit 0: pal_index[4:0], pal_value[10:5], shutter[11], turbo[12],
   // skip_request[17:13], zeros up to bit 23
   input  logic [s3dfd_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // rsp_tdata from bit 0: skip_frame[0], mode_3d[2:1], right_eye[3], skip_cleared[4],
   // zeros up to bit 7
   output logic [s3dfd_pkg::RSP_W-1:0]   rsp_tdata
);

   // Commands from the sequencer and status back from the datapath.
   s3dfd_pkg::cmd_type    cmd;
   s3dfd_pkg::status_type status;

   s3dfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status_i   (status),
      .cmd_o      (cmd)
   );

   s3dfd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd_i      (cmd),
      .status_o   (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/s3dfd_ctrl.sv
// Sequencer of the stereo 3D frame detector: accepts items, walks the palette, commits results.
module s3dfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  s3dfd_pkg::status_type status_i,
   output s3dfd_pkg::cmd_type    cmd_o
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_TAIL   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in         = state_ff;
      cmd_o            = '0;
      cmd_o.accept     = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && status_i.in_frame) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd_o.scan_start = 1'b1;
            state_in = status_i.need_scan ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            cmd_o.scan_read = 1'b1;
            if (status_i.scan_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status_i.rsp_free) begin
               cmd_o.commit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_frame_to_check: assert property (@(posedge clock) disable iff (reset)
      accept && status_i.in_frame |=> state_ff == ST_CHECK)
      else $error("frame transfer did not start the check step");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && !status_i.rsp_free |=> state_ff == ST_FINISH)
      else $error("result left finish without a free output slot");

   a_tail_after_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAIL |-> $past(state_ff) == ST_SCAN)
      else $error("tail step entered without a palette walk");

endmodule

### rtl/s3dfd_datapath.sv
// Datapath of the stereo 3D frame detector: palette memory, history state and result register.
module s3dfd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  s3dfd_pkg::cmd_type                cmd_i,
   output s3dfd_pkg::status_type             status_o,
   input  logic                              req_tuser,
   input  logic [s3dfd_pkg::REQ_W-1:0]       req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [s3dfd_pkg::RSP_W-1:0]       rsp_tdata
);

   localparam int AW = s3dfd_pkg::PAL_AW;
   localparam int CW = s3dfd_pkg::COLOR_W;
   localparam int SW = s3dfd_pkg::SKIP_W;

   // Palette storage; entries never written read as black through the valid bits.
   logic [CW-1:0]                         pal_mem [s3dfd_pkg::PALETTE_ENTRIES];
   logic [s3dfd_pkg::PALETTE_ENTRIES-1:0] pal_vld_ff;

   logic          wr_en;
   logic [AW-1:0] wr_idx;
   logic [CW-1:0] wr_val;

   // Captured frame fields.
   logic          shut_ff, turbo_ff;
   logic [SW-1:0] req_ff;

   // History state.
   logic                 shut_last_ff, shut_prev_ff, shut_active_ff, ana_active_ff, eye_ff;
   s3dfd_pkg::tint_type  tint_last_ff, tint_prev_ff;
   logic [SW-1:0]        cnt_ff;

   // Palette walk.
   logic [AW-1:0] addr_ff, addr_in;
   logic          rd_pend_ff, rd_ok_ff;
   logic [CW-1:0] rd_data_ff, rd_color;
   logic          red_ff, cyan_ff, other_ff;
   s3dfd_pkg::tint_type rd_class;

   // Result register.
   logic          rsp_valid_ff;
   logic          rsp_skip_ff, rsp_eye_ff, rsp_clr_ff;
   s3dfd_pkg::mode_type rsp_mode_ff;

   // Frame evaluation.
   logic                active_skip, cnt_wrap, shut_mode, need_scan;
   logic [SW-1:0]       period, cnt_in;
   logic                skip_in, clr_in, eye_in, ana_in;
   s3dfd_pkg::tint_type tint_in;
   s3dfd_pkg::mode_type mode_in;

   assign wr_en  = cmd_i.accept && (req_tuser == s3dfd_pkg::OP_PAL_WRITE);
   assign wr_idx = req_tdata[s3dfd_pkg::REQ_IDX_LSB +: AW];
   assign wr_val = req_tdata[s3dfd_pkg::REQ_VAL_LSB +: CW];

   assign shut_mode = (shut_ff != shut_last_ff) && (shut_ff == shut_prev_ff);
   assign need_scan = !shut_mode && !shut_active_ff;

   assign status_o.in_frame  = (req_tuser == s3dfd_pkg::OP_FRAME);
   assign status_o.need_scan = need_scan;
   assign status_o.scan_last = (addr_ff == AW'(s3dfd_pkg::PALETTE_ENTRIES - 1));
   assign status_o.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rd_color = rd_ok_ff ? rd_data_ff : '0;
   assign rd_class = s3dfd_pkg::colour_class(rd_color);

   always_comb begin
      if (addr_ff == AW'(s3dfd_pkg::BG_END - 1)) begin
         addr_in = AW'(s3dfd_pkg::SPR_START);
      end else begin
         addr_in = addr_ff + AW'(1);
      end
   end

   always_comb begin
      active_skip = turbo_ff || (req_ff != '0);
      period      = turbo_ff ? SW'(s3dfd_pkg::TURBO_PERIOD) : req_ff;
      cnt_wrap    = (cnt_ff >= period);
      skip_in     = active_skip && !cnt_wrap;
      cnt_in      = cnt_ff;
      if (active_skip) begin
         cnt_in = cnt_wrap ? '0 : cnt_ff + SW'(1);
      end
      clr_in  = 1'b0;
      eye_in  = eye_ff;
      ana_in  = ana_active_ff;
      tint_in = s3dfd_pkg::TINT_NONE;
      if (other_ff || (red_ff && cyan_ff) || (!red_ff && !cyan_ff)) begin
         tint_in = s3dfd_pkg::TINT_NONE;
      end else if (cyan_ff) begin
         tint_in = s3dfd_pkg::TINT_CYAN;
      end else begin
         tint_in = s3dfd_pkg::TINT_RED;
      end
      priority if (shut_mode) begin
         skip_in = 1'b0;
         eye_in  = !shut_ff;
      end else if (shut_active_ff) begin
         skip_in = 1'b0;
         cnt_in  = '0;
         clr_in  = 1'b1;
      end else begin
         if (tint_in != s3dfd_pkg::TINT_NONE) begin
            eye_in = cyan_ff;
         end
         ana_in = (tint_in != s3dfd_pkg::TINT_NONE) && (tint_in != tint_last_ff) &&
                  (tint_in == tint_prev_ff) && (tint_last_ff != s3dfd_pkg::TINT_NONE);
         if (ana_in) begin
            skip_in = 1'b0;
         end else if (ana_active_ff) begin
            skip_in = 1'b0;
            cnt_in  = '0;
            clr_in  = 1'b1;
         end
      end
      if (shut_mode) begin
         mode_in = s3dfd_pkg::MODE_SHUTTER;
      end else if (ana_in) begin
         mode_in = s3dfd_pkg::MODE_ANAGLYPH;
      end else begin
         mode_in = s3dfd_pkg::MODE_NORMAL;
      end
   end

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pal_mem[wr_idx] <= wr_val;
      end
      if (cmd_i.scan_read) begin
         rd_data_ff <= pal_mem[addr_ff];
         rd_ok_ff   <= pal_vld_ff[addr_ff];
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      if (cmd_i.accept && (req_tuser == s3dfd_pkg::OP_FRAME)) begin
         shut_ff  <= req_tdata[s3dfd_pkg::REQ_SHUT_BIT];
         turbo_ff <= req_tdata[s3dfd_pkg::REQ_TURBO_BIT];
         req_ff   <= req_tdata[s3dfd_pkg::REQ_SKIP_LSB +: SW];
      end
      if (cmd_i.scan_start) begin
         addr_ff  <= '0;
      end else if (cmd_i.scan_read) begin
         addr_ff  <= addr_in;
      end
      if (cmd_i.scan_start) begin
         red_ff   <= 1'b0;
         cyan_ff  <= 1'b0;
         other_ff <= 1'b0;
      end else if (rd_pend_ff) begin
         red_ff   <= red_ff   || (rd_class == s3dfd_pkg::TINT_RED);
         cyan_ff  <= cyan_ff  || (rd_class == s3dfd_pkg::TINT_CYAN);
         other_ff <= other_ff || (rd_class == s3dfd_pkg::TINT_OTHER);
      end
      if (cmd_i.commit) begin
         rsp_skip_ff <= skip_in;
         rsp_mode_ff <= mode_in;
         rsp_eye_ff  <= (mode_in != s3dfd_pkg::MODE_NORMAL) && eye_in;
         rsp_clr_ff  <= clr_in;
      end
   end

   // Control and history state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff     <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         shut_last_ff   <= 1'b0;
         shut_prev_ff   <= 1'b0;
         shut_active_ff <= 1'b0;
         ana_active_ff  <= 1'b0;
         eye_ff         <= 1'b0;
         tint_last_ff   <= s3dfd_pkg::TINT_NONE;
         tint_prev_ff   <= s3dfd_pkg::TINT_NONE;
         cnt_ff         <= '0;
      end else begin
         if (wr_en) begin
            pal_vld_ff[wr_idx] <= 1'b1;
         end
         rd_pend_ff <= cmd_i.scan_read;
         if (cmd_i.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd_i.commit) begin
            shut_prev_ff   <= shut_last_ff;
            shut_last_ff   <= shut_ff;
            shut_active_ff <= shut_mode;
            eye_ff         <= eye_in;
            cnt_ff         <= cnt_in;
            if (need_scan) begin
               ana_active_ff <= ana_in;
               tint_prev_ff  <= tint_last_ff;
               tint_last_ff  <= tint_in;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_clr_ff, rsp_eye_ff, rsp_mode_ff, rsp_skip_ff};

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd_i.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result committed over an untaken result");

   a_eye_needs_stereo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eye_ff |-> rsp_mode_ff != s3dfd_pkg::MODE_NORMAL)
      else $error("eye flag raised in normal mode");

   a_cleared_draws: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clr_ff |-> !rsp_skip_ff)
      else $error("skip clear reported on a skipped frame");

endmodule
